// File: hw/rtl/als_pkg.sv
// Shared types and constants for the annunciator lamp sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none
package als_pkg;

  localparam int CHANNELS  = 3;
  localparam int PERIOD_W  = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = PERIOD_W;

  localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST = PERIOD_W'(5);
  localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST = PERIOD_W'(5);

  typedef logic [CHANNELS-1:0] chan_vec_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAST_HALF_PERIOD = 1'b0,
    CFG_SLOW_HALF_PERIOD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    chan_vec_t seen;
    chan_vec_t flicker;
    chan_vec_t blink;
    chan_vec_t steady;
  } chan_state_t;

  typedef struct packed {
    logic fast_on;
    logic slow_on;
    logic ack;
    logic rst;
  } chan_ctrl_t;

endpackage
`default_nettype wire

// File: hw/rtl/annunciator_lamp_sequencer_unit.sv
// Annunciator lamp sequencer: one lamp per alarm channel, one lamp beat per tick beat.
// Tick beats enter an input register, then the flash dividers and channel logic
// (als_chan_logic) update state and load the result register. Takes one tick per
// cycle unless out_ready low stalls the result register. The result
// register holds while its beat waits on out_ready low, and the input register
// then holds too once it is full. Depends on als_pkg.
`default_nettype none
module annunciator_lamp_sequencer_unit
  import als_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire [CFG_IDX_W-1:0] cfg_index,
  input  wire [CFG_DAT_W-1:0] cfg_wdata,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire [CHANNELS-1:0]  in_alarm_bits,
  input  wire                 in_ack_button,
  input  wire                 in_reset_button,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [CHANNELS-1:0] out_lamp_bits
);

  logic [PERIOD_W-1:0] fast_period_r, slow_period_r;
  logic [PERIOD_W-1:0] fast_count_r, fast_count_nxt;
  logic [PERIOD_W-1:0] slow_count_r, slow_count_nxt;
  logic [1:0]          phase_r, phase_nxt;
  chan_state_t         state_r, state_nxt;

  logic                s1_valid_r;
  chan_vec_t           s1_alarm_r;
  logic                s1_ack_r, s1_rst_r;

  logic                out_valid_r;
  chan_vec_t           lamp_r, lamp_nxt;

  logic                advance;
  logic                fast_hit, slow_hit;
  chan_ctrl_t          ctrl;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_lamp_bits = lamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_period_r <= FAST_PERIOD_RST;
      slow_period_r <= SLOW_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_FAST_HALF_PERIOD: fast_period_r <= cfg_wdata;
        CFG_SLOW_HALF_PERIOD: slow_period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    fast_hit       = fast_count_r == fast_period_r;
    slow_hit       = slow_count_r == slow_period_r;
    fast_count_nxt = fast_hit ? '0 : fast_count_r + PERIOD_W'(1);
    slow_count_nxt = slow_hit ? '0 : slow_count_r + PERIOD_W'(1);
    phase_nxt      = phase_r ^ {slow_hit, fast_hit};
    ctrl.fast_on   = phase_nxt[0];
    ctrl.slow_on   = phase_nxt[1];
    ctrl.ack       = s1_ack_r;
    ctrl.rst       = s1_rst_r;
  end

  als_chan_logic u_chan (
    .alarm_bits (s1_alarm_r),
    .ctrl       (ctrl),
    .state_cur  (state_r),
    .state_upd  (state_nxt),
    .lamp_bits  (lamp_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_alarm_r <= in_alarm_bits;
      s1_ack_r   <= in_ack_button;
      s1_rst_r   <= in_reset_button;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      fast_count_r <= '0;
      slow_count_r <= '0;
      phase_r      <= '0;
      state_r      <= '0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        fast_count_r <= fast_count_nxt;
        slow_count_r <= slow_count_nxt;
        phase_r      <= phase_nxt;
        state_r      <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      lamp_r <= lamp_nxt;
    end
  end

  a_steady_seen : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.steady & ~state_r.seen) == '0)
    else $error("steady channel not marked seen");

  a_flicker_blink : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.flicker & state_r.blink) == '0)
    else $error("channel both flickering and blinking");

  a_load_out : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance) |=> out_valid_r)
    else $error("tick beat lost between stages");

  a_fast_toggle : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance && fast_hit) |=> (phase_r[0] != $past(phase_r[0])))
    else $error("fast phase failed to toggle");

  a_hold_idle : assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |=> $stable(state_r))
    else $error("channel state changed without a tick beat");

endmodule
`default_nettype wire

// File: hw/rtl/als_chan_logic.sv
// Per-channel lamp mode update for one tick: flicker, steady, blink and idle.
// Depends on als_pkg for the channel state struct and control struct.
`default_nettype none
module als_chan_logic
  import als_pkg::*;
(
  input  wire chan_vec_t   alarm_bits,
  input  wire chan_ctrl_t  ctrl,
  input  wire chan_state_t state_cur,
  output chan_state_t      state_upd,
  output chan_vec_t        lamp_bits
);

  always_comb begin
    state_upd = state_cur;
    lamp_bits = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (ctrl.ack || state_cur.steady[i]) begin
        if (alarm_bits[i]) begin
          lamp_bits[i]        = 1'b1;
          state_upd.steady[i] = 1'b1;
          state_upd.seen[i]   = 1'b1;
        end else if (state_cur.seen[i]) begin
          state_upd.blink[i]   = 1'b1;
          state_upd.steady[i]  = 1'b0;
          state_upd.flicker[i] = 1'b0;
          lamp_bits[i]         = ctrl.slow_on;
        end else begin
          state_upd.seen[i]    = 1'b0;
          state_upd.blink[i]   = 1'b0;
          state_upd.flicker[i] = 1'b0;
          lamp_bits[i]         = 1'b0;
        end
      end else if (!state_cur.blink[i] && (state_cur.flicker[i] || alarm_bits[i])) begin
        state_upd.seen[i]    = 1'b1;
        state_upd.flicker[i] = 1'b1;
        state_upd.steady[i]  = 1'b0;
        lamp_bits[i]         = ctrl.fast_on;
      end else if (!state_cur.blink[i] || ctrl.rst) begin
        state_upd.seen[i]    = 1'b0;
        state_upd.blink[i]   = 1'b0;
        state_upd.flicker[i] = 1'b0;
        lamp_bits[i]         = 1'b0;
      end else begin
        lamp_bits[i] = ctrl.slow_on;
      end
    end
  end

endmodule
`default_nettype wire

// File: tb/annunciator_lamp_sequencer_unit_tb.sv
// Self-checking bench for annunciator_lamp_sequencer_unit: directed and random tick beats,
// predicted lamp vectors checked in order against the result channel.
// Depends on als_pkg and the annunciator_lamp_sequencer_unit RTL.
module annunciator_lamp_sequencer_unit_tb;
  import als_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SEGMENTS    = 4;
  localparam int SEG_TICKS   = 160;

  class lamp_scoreboard;
    logic [PERIOD_W-1:0] fast_period;
    logic [PERIOD_W-1:0] slow_period;
    logic [PERIOD_W-1:0] fast_count;
    logic [PERIOD_W-1:0] slow_count;
    logic                fast_phase;
    logic                slow_phase;
    chan_state_t         chans;
    chan_vec_t           lamps;
    chan_vec_t           expected_lamps[$];
    int                  errors;

    function new();
      fast_period = FAST_PERIOD_RST;
      slow_period = SLOW_PERIOD_RST;
      fast_count  = '0;
      slow_count  = '0;
      fast_phase  = 1'b0;
      slow_phase  = 1'b0;
      chans       = '0;
      lamps       = '0;
      errors      = 0;
    endfunction

    function void set_period(cfg_reg_t idx, logic [PERIOD_W-1:0] value);
      if (idx == CFG_FAST_HALF_PERIOD) fast_period = value;
      else slow_period = value;
    endfunction

    function int pending();
      return expected_lamps.size();
    endfunction

    function void note_tick(chan_vec_t alarms, logic ack, logic rst);
      if (fast_count == fast_period) begin
        fast_count = '0;
        fast_phase = ~fast_phase;
      end else begin
        fast_count = fast_count + 1'b1;
      end
      if (slow_count == slow_period) begin
        slow_count = '0;
        slow_phase = ~slow_phase;
      end else begin
        slow_count = slow_count + 1'b1;
      end
      for (int i = 0; i < CHANNELS; i++) begin
        logic a, seen, fl, bl, stdy, lamp;
        a    = alarms[i];
        seen = chans.seen[i];
        fl   = chans.flicker[i];
        bl   = chans.blink[i];
        stdy = chans.steady[i];
        lamp = lamps[i];
        if (ack || stdy) begin
          if (a) begin
            lamp = 1'b1;
            stdy = 1'b1;
            seen = 1'b1;
          end else if (seen) begin
            bl   = 1'b1;
            stdy = 1'b0;
            fl   = 1'b0;
            lamp = slow_phase;
          end else begin
            seen = 1'b0;
            lamp = 1'b0;
            bl   = 1'b0;
            fl   = 1'b0;
          end
        end else begin
          if (!bl && (fl || a)) begin
            seen = 1'b1;
            fl   = 1'b1;
            stdy = 1'b0;
            lamp = fast_phase;
          end
          if ((!bl && !fl && !a) || (bl && rst)) begin
            seen = 1'b0;
            lamp = 1'b0;
            bl   = 1'b0;
            fl   = 1'b0;
          end else if (bl) begin
            lamp = slow_phase;
          end
        end
        chans.seen[i]    = seen;
        chans.flicker[i] = fl;
        chans.blink[i]   = bl;
        chans.steady[i]  = stdy;
        lamps[i]         = lamp;
      end
      expected_lamps.push_back(lamps);
    endfunction

    function void check_lamps(chan_vec_t got);
      chan_vec_t want;
      if (expected_lamps.size() == 0) begin
        if (errors < 10) $display("lamp beat with none expected: lamp_bits %b", got);
        errors++;
        return;
      end
      want = expected_lamps.pop_front();
      if (got !== want) begin
        if (errors < 10) $display("lamp_bits mismatch: expected %b actual %b", want, got);
        errors++;
      end
    endfunction
  endclass

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata       = '0;
  logic                 in_valid        = 1'b0;
  logic                 in_ready;
  logic [CHANNELS-1:0]  in_alarm_bits   = '0;
  logic                 in_ack_button   = 1'b0;
  logic                 in_reset_button = 1'b0;
  logic                 out_valid;
  logic                 out_ready       = 1'b0;
  logic [CHANNELS-1:0]  out_lamp_bits;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles  = 0;

  lamp_scoreboard scoreboard = new();

  logic [4:0] opening_ticks [25] = '{
    5'b000_0_0, 5'b001_0_0, 5'b001_0_0, 5'b001_0_1, 5'b001_1_0,
    5'b001_0_1, 5'b000_0_0, 5'b000_0_0, 5'b000_1_1, 5'b000_0_1,
    5'b111_0_0, 5'b111_0_0, 5'b110_0_0, 5'b110_1_0, 5'b000_0_0,
    5'b000_0_1, 5'b010_0_0, 5'b000_1_0, 5'b101_0_0, 5'b111_0_1,
    5'b111_1_1, 5'b000_1_0, 5'b000_0_0, 5'b111_0_1, 5'b000_0_0
  };

  annunciator_lamp_sequencer_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_alarm_bits   (in_alarm_bits),
    .in_ack_button   (in_ack_button),
    .in_reset_button (in_reset_button),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_lamp_bits   (out_lamp_bits)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        scoreboard.note_tick(in_alarm_bits, in_ack_button, in_reset_button);
      if (out_valid && out_ready)
        scoreboard.check_lamps(out_lamp_bits);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles = stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic send_tick(input chan_vec_t alarms, input logic ack, input logic rst);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_alarm_bits   <= alarms;
    in_ack_button   <= ack;
    in_reset_button <= rst;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_lamps();
    @(negedge clk);
    in_valid <= 1'b0;
    while (scoreboard.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_period(input cfg_reg_t idx, input logic [PERIOD_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    scoreboard.set_period(idx, value);
  endtask

  task automatic set_periods(input logic [PERIOD_W-1:0] fast, input logic [PERIOD_W-1:0] slow);
    write_period(CFG_FAST_HALF_PERIOD, fast);
    write_period(CFG_SLOW_HALF_PERIOD, slow);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_ticks(input int count);
    chan_vec_t alarms;
    int        r;
    alarms = '0;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 6) alarms = chan_vec_t'($urandom);
      else if (r < 26) alarms[$urandom_range(CHANNELS-1)] ^= 1'b1;
      send_tick(alarms, $urandom_range(99) < 10, $urandom_range(99) < 10);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_periods(8'd1, 8'd3);
    foreach (opening_ticks[k])
      send_tick(opening_ticks[k][4:2], opening_ticks[k][1], opening_ticks[k][0]);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 52;
        end
        1: begin
          send_idle_pct = 52;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        drain_lamps();
        case (seg)
          0: set_periods(8'd0, 8'hFF);
          1: set_periods(8'hFF, 8'd0);
          2: set_periods(8'($urandom_range(3)), 8'($urandom_range(15)));
          default: set_periods(8'($urandom_range(255)), 8'($urandom_range(7)));
        endcase
        random_ticks(SEG_TICKS);
      end
    end

    drain_lamps();
    repeat (8) @(posedge clk);
    if (scoreboard.errors == 0 && scoreboard.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
